// ===== rtl/sorted_timer_expiry_queue_core_assert.svh =====
// Assertion macros for the checker file of the timer queue.
// Needs nothing beyond the including file's clock and reset names.
`ifndef SORTED_TIMER_EXPIRY_QUEUE_CORE_ASSERT_SVH
`define SORTED_TIMER_EXPIRY_QUEUE_CORE_ASSERT_SVH

// same-cycle implication, masked during reset
`define STQ_AST_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, masked during reset
`define STQ_AST_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also runs through reset
`define STQ_AST_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/stq_pkg.sv =====
// Package for the sorted timer expiry queue: transfer payload types,
// request and status codes, fixed field widths. No dependencies.
`default_nettype none

package stq_pkg;

  localparam int ID_W   = 5;
  localparam int TIME_W = 32;
  localparam int POP_W  = 6;

  // most timers released by a single tick
  localparam logic [POP_W-1:0] MAX_POP = 6'd32;

  // request kinds
  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_ADJUST = 2'd1;
  localparam logic [1:0] REQ_DELETE = 2'd2;
  localparam logic [1:0] REQ_TICK   = 2'd3;

  // result status
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_EXISTS    = 2'd3;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [ID_W-1:0]   timer_id;
    logic [TIME_W-1:0] new_expire;
    logic [TIME_W-1:0] now;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0] expired_id;
    logic            expired;
    logic [1:0]      status;
    logic            last;
  } resp_t;

  // one slot of the sorted table
  typedef struct packed {
    logic [TIME_W-1:0] expire;
    logic [ID_W-1:0]   owner;
  } entry_t;

endpackage

`default_nettype wire

// ===== rtl/sorted_timer_expiry_queue_core.sv =====
// Sorted timer expiry queue: table of timers in one synchronous memory,
// kept in ascending expiry order. Depends on stq_pkg.
//
//   channel | direction | payload         | handshake
//   in_     | input     | stq_pkg::req_t  | in_valid / in_ready
//   out_    | output    | stq_pkg::resp_t | out_valid / out_ready
//
// Add/adjust/delete: an id search, then for adjust and delete a shift-down
// pass, for add and adjust an order search and a shift-up pass, each about
// one entry per cycle on the memory's single read and write port. Tick:
// reads and checks the front timer, releasing it if due, until the table is
// empty, MAX_POP timers are out or it stops at a timer not yet due.
// The table is a ring; a tick releases from the front by moving the head.
// rst_n clears count, head and control; memory contents are left as they are.
// A held result stalls the sequencer until out_ready; a new request is taken
// while the last result still waits in the output register.
`default_nettype none

module sorted_timer_expiry_queue_core #(
  parameter int DEPTH = 32
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire stq_pkg::req_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output stq_pkg::resp_t      out_data
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [IW:0]   DEPTH_X   = (IW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C   = CW'(DEPTH);
  localparam logic [IW-1:0] HEAD_LAST = IW'(DEPTH - 1);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_FIND     = 4'd1;
  localparam logic [3:0] S_REMOVE   = 4'd2;
  localparam logic [3:0] S_SEARCH   = 4'd3;
  localparam logic [3:0] S_SHIFT    = 4'd4;
  localparam logic [3:0] S_RESP     = 4'd5;
  localparam logic [3:0] S_TICK_RD  = 4'd6;
  localparam logic [3:0] S_TICK_CHK = 4'd7;

  // logical slot to ring address
  function automatic logic [IW-1:0] ring_addr(input logic [IW-1:0] base,
                                              input logic [IW-1:0] off);
    logic [IW:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= DEPTH_X) s = s - DEPTH_X;
    return s[IW-1:0];
  endfunction

  // entry memory
  stq_pkg::entry_t mem [DEPTH];
  stq_pkg::entry_t rdata_r;
  stq_pkg::entry_t wdata;
  logic            rd_en, wr_en;
  logic [IW-1:0]   rd_lidx, wr_lidx;

  // control state
  logic [3:0]               state_r, state_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  logic [IW-1:0]            head_r, head_nxt;
  stq_pkg::req_t            req_r, req_nxt;
  logic [CW-1:0]            scan_r, scan_nxt;
  logic [IW-1:0]            chk_r, chk_nxt;
  logic                     rd_pend_r, rd_pend_nxt;
  logic [IW-1:0]            pos_r, pos_nxt;
  logic [CW-1:0]            mv_r, mv_nxt;
  logic [IW-1:0]            src_r, src_nxt;
  logic [stq_pkg::POP_W-1:0] pop_r, pop_nxt;
  logic                     hold_vld_r, hold_vld_nxt;
  logic [stq_pkg::ID_W-1:0] hold_id_r, hold_id_nxt;
  stq_pkg::resp_t           resp_r, resp_nxt;
  logic                     out_vld_r, out_vld_nxt;
  stq_pkg::resp_t           out_data_r, out_data_nxt;

  logic            out_free;
  logic            out_load;
  stq_pkg::resp_t  out_load_data;
  stq_pkg::resp_t  tick_final;

  assign out_free  = !out_vld_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  // closing result of a tick: the held timer, or a single not-expired mark
  always_comb begin
    tick_final.status = stq_pkg::ST_OK;
    tick_final.last   = 1'b1;
    if (hold_vld_r) begin
      tick_final.expired_id = hold_id_r;
      tick_final.expired    = 1'b1;
    end else begin
      tick_final.expired_id = '0;
      tick_final.expired    = 1'b0;
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    head_nxt      = head_r;
    req_nxt       = req_r;
    scan_nxt      = scan_r;
    chk_nxt       = chk_r;
    rd_pend_nxt   = rd_pend_r;
    pos_nxt       = pos_r;
    mv_nxt        = mv_r;
    src_nxt       = src_r;
    pop_nxt       = pop_r;
    hold_vld_nxt  = hold_vld_r;
    hold_id_nxt   = hold_id_r;
    resp_nxt      = resp_r;
    rd_en         = 1'b0;
    rd_lidx       = '0;
    wr_en         = 1'b0;
    wr_lidx       = '0;
    wdata         = rdata_r;
    out_load      = 1'b0;
    out_load_data = resp_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt      = in_data;
          scan_nxt     = '0;
          rd_pend_nxt  = 1'b0;
          pop_nxt      = '0;
          hold_vld_nxt = 1'b0;
          resp_nxt.expired_id = in_data.timer_id;
          resp_nxt.expired    = 1'b0;
          resp_nxt.status     = stq_pkg::ST_OK;
          resp_nxt.last       = 1'b1;
          state_nxt = (in_data.req_type == stq_pkg::REQ_TICK) ? S_TICK_RD : S_FIND;
        end
      end

      // look for the id, one slot per cycle
      S_FIND: begin
        if (rd_pend_r && rdata_r.owner == req_r.timer_id) begin
          rd_pend_nxt = 1'b0;
          if (req_r.req_type == stq_pkg::REQ_ADD) begin
            resp_nxt.status = stq_pkg::ST_EXISTS;
            state_nxt       = S_RESP;
          end else begin
            pos_nxt   = chk_r;
            scan_nxt  = CW'(chk_r) + CW'(1);
            state_nxt = S_REMOVE;
          end
        end else if (scan_r < count_r) begin
          rd_en       = 1'b1;
          rd_lidx     = scan_r[IW-1:0];
          chk_nxt     = scan_r[IW-1:0];
          scan_nxt    = scan_r + CW'(1);
          rd_pend_nxt = 1'b1;
        end else begin
          rd_pend_nxt = 1'b0;
          if (req_r.req_type != stq_pkg::REQ_ADD) begin
            resp_nxt.status = stq_pkg::ST_NOT_FOUND;
            state_nxt       = S_RESP;
          end else if (count_r == DEPTH_C) begin
            resp_nxt.status = stq_pkg::ST_FULL;
            state_nxt       = S_RESP;
          end else begin
            scan_nxt  = '0;
            state_nxt = S_SEARCH;
          end
        end
      end

      // close the gap: slot i takes slot i+1, each read registered ahead of its write
      S_REMOVE: begin
        if (rd_pend_r) begin
          wr_en   = 1'b1;
          wr_lidx = chk_r - IW'(1);
          wdata   = rdata_r;
        end
        if (scan_r < count_r) begin
          rd_en       = 1'b1;
          rd_lidx     = scan_r[IW-1:0];
          chk_nxt     = scan_r[IW-1:0];
          scan_nxt    = scan_r + CW'(1);
          rd_pend_nxt = 1'b1;
        end else begin
          rd_pend_nxt = 1'b0;
          if (!rd_pend_r) begin
            count_nxt = count_r - CW'(1);
            if (req_r.req_type == stq_pkg::REQ_ADJUST) begin
              scan_nxt  = '0;
              state_nxt = S_SEARCH;
            end else begin
              state_nxt = S_RESP;
            end
          end
        end
      end

      // first slot with a later expiry; equal expiries stay ahead
      S_SEARCH: begin
        if (rd_pend_r && rdata_r.expire > req_r.new_expire) begin
          rd_pend_nxt = 1'b0;
          pos_nxt     = chk_r;
          mv_nxt      = count_r - CW'(chk_r);
          src_nxt     = count_r[IW-1:0] - IW'(1);
          state_nxt   = S_SHIFT;
        end else if (scan_r < count_r) begin
          rd_en       = 1'b1;
          rd_lidx     = scan_r[IW-1:0];
          chk_nxt     = scan_r[IW-1:0];
          scan_nxt    = scan_r + CW'(1);
          rd_pend_nxt = 1'b1;
        end else begin
          rd_pend_nxt = 1'b0;
          pos_nxt     = count_r[IW-1:0];
          mv_nxt      = '0;
          state_nxt   = S_SHIFT;
        end
      end

      // open the gap from the tail down, then place the new entry
      S_SHIFT: begin
        if (rd_pend_r) begin
          wr_en   = 1'b1;
          wr_lidx = chk_r + IW'(1);
          wdata   = rdata_r;
        end
        if (mv_r != '0) begin
          rd_en       = 1'b1;
          rd_lidx     = src_r;
          chk_nxt     = src_r;
          src_nxt     = src_r - IW'(1);
          mv_nxt      = mv_r - CW'(1);
          rd_pend_nxt = 1'b1;
        end else begin
          rd_pend_nxt = 1'b0;
          if (!rd_pend_r) begin
            wr_en        = 1'b1;
            wr_lidx      = pos_r;
            wdata.expire = req_r.new_expire;
            wdata.owner  = req_r.timer_id;
            count_nxt    = count_r + CW'(1);
            state_nxt    = S_RESP;
          end
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_load_data = resp_r;
          state_nxt     = S_IDLE;
        end
      end

      // fetch the front slot
      S_TICK_RD: begin
        if (count_r != '0 && pop_r < stq_pkg::MAX_POP) begin
          rd_en     = 1'b1;
          rd_lidx   = '0;
          state_nxt = S_TICK_CHK;
        end else begin
          resp_nxt  = tick_final;
          state_nxt = S_RESP;
        end
      end

      // release the front if due; the previous release goes out once its
      // successor is known, so its last mark is right
      S_TICK_CHK: begin
        if (rdata_r.expire <= req_r.now) begin
          if (!hold_vld_r || out_free) begin
            if (hold_vld_r) begin
              out_load                 = 1'b1;
              out_load_data.expired_id = hold_id_r;
              out_load_data.expired    = 1'b1;
              out_load_data.status     = stq_pkg::ST_OK;
              out_load_data.last       = 1'b0;
            end
            hold_id_nxt  = rdata_r.owner;
            hold_vld_nxt = 1'b1;
            head_nxt     = (head_r == HEAD_LAST) ? '0 : head_r + IW'(1);
            count_nxt    = count_r - CW'(1);
            pop_nxt      = pop_r + stq_pkg::POP_W'(1);
            state_nxt    = S_TICK_RD;
          end
        end else begin
          resp_nxt  = tick_final;
          state_nxt = S_RESP;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    out_data_nxt = out_data_r;
    out_vld_nxt  = out_vld_r;
    if (out_load) begin
      out_data_nxt = out_load_data;
      out_vld_nxt  = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  // memory port: one write, one registered read; phases never overlap an
  // address between the write and the read of the same cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[ring_addr(head_r, wr_lidx)] <= wdata;
    end
    if (rd_en) begin
      rdata_r <= mem[ring_addr(head_r, rd_lidx)];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      count_r    <= '0;
      head_r     <= '0;
      rd_pend_r  <= 1'b0;
      hold_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      head_r     <= head_nxt;
      rd_pend_r  <= rd_pend_nxt;
      hold_vld_r <= hold_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    scan_r     <= scan_nxt;
    chk_r      <= chk_nxt;
    pos_r      <= pos_nxt;
    mv_r       <= mv_nxt;
    src_r      <= src_nxt;
    pop_r      <= pop_nxt;
    hold_id_r  <= hold_id_nxt;
    resp_r     <= resp_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/stq_checker.sv =====
// Port-level checks for the sorted timer expiry queue, bound to the top level.
// Depends on stq_pkg and sorted_timer_expiry_queue_core_assert.svh.
`default_nettype none
`include "sorted_timer_expiry_queue_core_assert.svh"

module stq_checker (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           out_valid,
  input wire logic           out_ready,
  input wire stq_pkg::resp_t out_data
);

  // a waiting result stays offered
  `STQ_AST_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "out_valid dropped")

  // reset empties the output register
  `STQ_AST_ALWAYS(a_out_reset, clk, !rst_n, !out_valid, "out_valid after reset")

  // only a released timer can be followed by more results of the same request
  `STQ_AST_NOW(a_status_last, clk, rst_n, out_valid && !out_data.expired, out_data.last, "non-expiry result without last")

  // released timers always carry ok status
  `STQ_AST_NOW(a_expired_ok, clk, rst_n, out_valid && out_data.expired, out_data.status == stq_pkg::ST_OK, "expiry result with bad status")

endmodule

bind sorted_timer_expiry_queue_core stq_checker u_stq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

// ===== tb/sv/sorted_timer_expiry_queue_core_chk.sv =====
// Transfer checker for the sorted timer expiry queue: keeps its own sorted
// timer table, predicts every result and compares each result transfer.
// Depends on stq_pkg.
`timescale 1ns / 1ps

module sorted_timer_expiry_queue_core_chk #(
  parameter int DEPTH = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_ready,
  input  stq_pkg::req_t  in_data,
  input  logic           out_valid,
  input  logic           out_ready,
  input  stq_pkg::resp_t out_data,
  output int             err_count,
  output int             outstanding,
  output int             req_total,
  output int             resp_total,
  output int             expiry_total
);
  import stq_pkg::*;

  // shadow copy of the sorted table, front is the earliest expiry
  logic [TIME_W-1:0] slot_expire [DEPTH];
  logic [ID_W-1:0]   slot_owner  [DEPTH];
  int                live_timers = 0;

  // results still owed by the block, oldest first
  resp_t awaited_resp[$];

  int errs   = 0;
  int n_req  = 0;
  int n_resp = 0;
  int n_exp  = 0;

  function automatic int slot_of(input logic [ID_W-1:0] id);
    for (int i = 0; i < live_timers; i++)
      if (slot_owner[i] == id) return i;
    return -1;
  endfunction

  // close the gap left by a removed timer
  function automatic void drop_slot(input int pos);
    for (int i = pos; i + 1 < live_timers; i++) begin
      slot_expire[i] = slot_expire[i + 1];
      slot_owner[i]  = slot_owner[i + 1];
    end
    live_timers--;
  endfunction

  // new timer goes behind every timer with an equal or earlier expiry
  function automatic void place_timer(input logic [ID_W-1:0] id,
                                      input logic [TIME_W-1:0] at);
    int pos;
    pos = 0;
    while (pos < live_timers && slot_expire[pos] <= at) pos++;
    for (int i = live_timers; i > pos; i--) begin
      slot_expire[i] = slot_expire[i - 1];
      slot_owner[i]  = slot_owner[i - 1];
    end
    slot_expire[pos] = at;
    slot_owner[pos]  = id;
    live_timers++;
  endfunction

  function automatic bit front_due(input logic [TIME_W-1:0] t_now, input int popped);
    return popped < MAX_POP && live_timers > 0 && slot_expire[0] <= t_now;
  endfunction

  // expected results of one accepted request
  function automatic void predict_timer_request(input req_t r);
    resp_t res;
    int    pos;
    int    popped;
    res        = '0;
    res.status = ST_OK;
    if (r.req_type == REQ_TICK) begin
      popped = 0;
      while (front_due(r.now, popped)) begin
        res.expired_id = slot_owner[0];
        res.expired    = 1'b1;
        drop_slot(0);
        popped++;
        res.last = !front_due(r.now, popped);
        awaited_resp.push_back(res);
      end
      n_exp += popped;
      // nothing due: a single idle report
      if (popped == 0) begin
        res.last = 1'b1;
        awaited_resp.push_back(res);
      end
    end else begin
      res.expired_id = r.timer_id;
      res.last       = 1'b1;
      pos            = slot_of(r.timer_id);
      if (r.req_type == REQ_ADD) begin
        // presence wins over a full table
        if (pos >= 0)
          res.status = ST_EXISTS;
        else if (live_timers >= DEPTH)
          res.status = ST_FULL;
        else
          place_timer(r.timer_id, r.new_expire);
      end else if (pos < 0) begin
        res.status = ST_NOT_FOUND;
      end else begin
        drop_slot(pos);
        if (r.req_type == REQ_ADJUST) place_timer(r.timer_id, r.new_expire);
      end
      awaited_resp.push_back(res);
    end
  endfunction

  function automatic void check_result(input resp_t got);
    resp_t want;
    if (awaited_resp.size() == 0) begin
      $error("result transfer with nothing expected: id %0d expired %0d status %0d last %0d",
             got.expired_id, got.expired, got.status, got.last);
      errs++;
    end else begin
      want = awaited_resp.pop_front();
      if (got.expired_id !== want.expired_id) begin
        $error("expired_id: expected %0d, got %0d", want.expired_id, got.expired_id);
        errs++;
      end
      if (got.expired !== want.expired) begin
        $error("expired: expected %0d, got %0d", want.expired, got.expired);
        errs++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errs++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        errs++;
      end
    end
  endfunction

  // sample both channels at the edge; a result can never belong to the
  // request taken at the same edge, so the order here does not matter
  always @(posedge clk) begin
    if (!rst_n) begin
      live_timers = 0;
      awaited_resp.delete();
    end else begin
      if (out_valid && out_ready) begin
        check_result(out_data);
        n_resp++;
      end
      if (in_valid && in_ready) begin
        predict_timer_request(in_data);
        n_req++;
      end
    end
    err_count    <= errs;
    outstanding  <= awaited_resp.size();
    req_total    <= n_req;
    resp_total   <= n_resp;
    expiry_total <= n_exp;
  end

endmodule

// ===== tb/sv/sorted_timer_expiry_queue_core_tb.sv =====
// Top of the timer queue testbench: clock, reset, request stimulus and
// output back-pressure. Depends on stq_pkg, the core and its checker.
`timescale 1ns / 1ps

module sorted_timer_expiry_queue_core_tb;
  import stq_pkg::*;

  localparam int DEPTH        = 32;
  localparam int RESET_CYCLES = 12;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 120;

  logic  clk       = 1'b0;
  logic  rst_n     = 1'b0;
  logic  in_valid  = 1'b0;
  logic  in_ready;
  req_t  in_data   = '0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  resp_t out_data;

  int err_count;
  int outstanding;
  int req_total;
  int resp_total;
  int expiry_total;

  bit tx_gaps    = 1'b1;
  bit rx_gaps    = 1'b1;
  int hold_asked = 0;
  int hold_done  = 0;

  // moving notion of the current second for well-formed traffic
  logic [TIME_W-1:0] wall_sec = '0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  sorted_timer_expiry_queue_core #(
    .DEPTH(DEPTH)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  sorted_timer_expiry_queue_core_chk #(
    .DEPTH(DEPTH)
  ) chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .err_count   (err_count),
    .outstanding (outstanding),
    .req_total   (req_total),
    .resp_total  (resp_total),
    .expiry_total(expiry_total)
  );

  // hard stop
  initial begin
    #1000000;
    $display("sorted_timer_expiry_queue_core_tb: done, errors");
    $finish;
  end

  // result side: random stall bursts, or one long hold when asked
  initial begin
    forever begin
      @(posedge clk);
      if (hold_done != hold_asked) begin
        hold_done++;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_ready <= 1'b1;
      end else if (rx_gaps && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic req_t make_req(input logic [1:0] kind, input logic [ID_W-1:0] id,
                                    input logic [TIME_W-1:0] at,
                                    input logic [TIME_W-1:0] t_now);
    req_t r;
    r.req_type   = kind;
    r.timer_id   = id;
    r.new_expire = at;
    r.now        = t_now;
    return r;
  endfunction

  // one request transfer; valid stays up afterwards for back-to-back items
  task automatic issue(input req_t r);
    if (tx_gaps && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk iff in_ready);
  endtask

  // stop offering and wait for every owed result
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk iff outstanding == 0);
  endtask

  // mostly coherent add/adjust/delete/tick around a moving clock, some noise
  task automatic random_traffic(input int n_items);
    int pick;
    wall_sec = $urandom;
    for (int k = 0; k < n_items; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        issue(make_req(2'($urandom), 5'($urandom), $urandom, $urandom));
      end else if (pick < 45) begin
        issue(make_req(REQ_ADD, 5'($urandom), wall_sec + $urandom_range(0, 60),
                       $urandom));
      end else if (pick < 60) begin
        issue(make_req(REQ_ADJUST, 5'($urandom), wall_sec + $urandom_range(0, 60),
                       $urandom));
      end else if (pick < 75) begin
        issue(make_req(REQ_DELETE, 5'($urandom), $urandom, $urandom));
      end else begin
        issue(make_req(REQ_TICK, 5'($urandom), $urandom, wall_sec));
        wall_sec = wall_sec + $urandom_range(0, 20);
      end
    end
  endtask

  // clear the table, fill every slot, retry one id, then release all in one tick
  task automatic fill_and_flush();
    int rot;
    rot      = $urandom_range(0, DEPTH - 1);
    wall_sec = $urandom;
    issue(make_req(REQ_TICK, '0, '0, '1));
    for (int k = 0; k < DEPTH; k++)
      issue(make_req(REQ_ADD, 5'((k + rot) % DEPTH), wall_sec + $urandom_range(0, 30),
                     $urandom));
    issue(make_req(REQ_ADD, 5'(rot), $urandom, $urandom));
    issue(make_req(REQ_TICK, '0, '0, '1));
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // empty table: nothing due, nothing to find
    issue(make_req(REQ_TICK,   5'd0,  32'd0, 32'd0));
    issue(make_req(REQ_DELETE, 5'd5,  32'd0, 32'd0));
    issue(make_req(REQ_ADJUST, 5'd7,  32'd9, 32'd0));
    // id and expiry extremes, duplicate add
    issue(make_req(REQ_ADD,    5'd0,  32'd0, 32'd0));
    issue(make_req(REQ_ADD,    5'd31, '1,    '1));
    issue(make_req(REQ_ADD,    5'd0,  32'd77, 32'd0));
    // equal expiries keep arrival order
    issue(make_req(REQ_ADD,    5'd10, 32'd100, 32'd0));
    issue(make_req(REQ_ADD,    5'd11, 32'd100, 32'd0));
    issue(make_req(REQ_ADD,    5'd12, 32'd100, 32'd0));
    issue(make_req(REQ_ADD,    5'd13, 32'd100, 32'd0));
    // adjust to same, earlier and later expiry
    issue(make_req(REQ_ADJUST, 5'd10, 32'd100,  32'd0));
    issue(make_req(REQ_ADJUST, 5'd11, 32'd50,   32'd0));
    issue(make_req(REQ_ADJUST, 5'd12, 32'd5000, 32'd0));
    issue(make_req(REQ_TICK,   5'd0,  32'd0,    32'd0));
    issue(make_req(REQ_TICK,   5'd0,  32'd0,    32'd100));
    issue(make_req(REQ_DELETE, 5'd12, 32'd0,    32'd0));
    issue(make_req(REQ_DELETE, 5'd12, 32'd0,    32'd0));
    // top of the time range
    issue(make_req(REQ_TICK,   5'd0,  32'd0,    32'hFFFF_FFFE));
    issue(make_req(REQ_TICK,   5'd0,  32'd0,    '1));
    drain();

    random_traffic(45);
    // sender waits for every result before going on
    drain();

    // long output hold as the table fill and flush begins
    hold_asked++;
    fill_and_flush();
    random_traffic(45);
    drain();

    // closing stretch at full rate
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    random_traffic(40);
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d requests and %0d results, %0d of them expiries,",
             req_total, resp_total, expiry_total);
    $display("including a full-table flush and a long output hold");
    if (err_count == 0 && outstanding == 0)
      $display("sorted_timer_expiry_queue_core_tb: done, clean");
    else
      $display("sorted_timer_expiry_queue_core_tb: done, errors");
    $finish;
  end

endmodule
